### hdl/indexed_min_heap_queue_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the indexed min-heap queue
// Concurrent checks on the rising edge of clk; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTH
// check that is switched off while reset is low
`define HMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also covers the reset cycles
`define HMQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HMQ_ASSERT(lbl, prop, msg)
`define HMQ_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### hdl/hmq_pkg.sv
// ---------------------------------------------------------------------------
// hmq_pkg
// Shared widths, operation and status codes for the indexed min-heap queue.
// ---------------------------------------------------------------------------
package hmq_pkg;

  localparam int KEY_W  = 32;
  localparam int PL_W   = 32;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 9;
  localparam int CFG_W  = 9;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 2'd0,
    FN_SET_KEY = 2'd1,
    FN_DEL_MIN = 2'd2,
    FN_REMOVE  = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUP       = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // signed key order, smaller first
  function automatic logic key_lt(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

### hdl/hmq_level_cell.sv
// ---------------------------------------------------------------------------
// hmq_level_cell
// One heap level: holds the 2^LEVEL entries of that level, one write port and
// two registered read ports. Addresses are heap positions; a cell answers
// only for positions on its own level and returns zero otherwise.
// ---------------------------------------------------------------------------
module hmq_level_cell #(
  parameter int LEVEL = 0,
  parameter int AW    = 10,
  parameter int ENT_W = 74
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ENT_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_a_addr,
  input  logic [AW-1:0]    rd_b_addr,
  output logic [ENT_W-1:0] rd_a_data,
  output logic [ENT_W-1:0] rd_b_data
);

  localparam int DEPTH = 1 << LEVEL;
  localparam int IDX_W = (LEVEL > 0) ? LEVEL : 1;

  logic [ENT_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0] wr_idx, a_idx, b_idx;
  logic             wr_hit, a_hit, b_hit;
  logic             a_hit_r, b_hit_r;
  logic [ENT_W-1:0] a_q_r, b_q_r;

  // level decode: position lies in [2^LEVEL, 2^(LEVEL+1))
  assign wr_hit = (wr_addr >> LEVEL) == AW'(1);
  assign a_hit  = (rd_a_addr >> LEVEL) == AW'(1);
  assign b_hit  = (rd_b_addr >> LEVEL) == AW'(1);
  assign wr_idx = (LEVEL == 0) ? '0 : wr_addr[IDX_W-1:0];
  assign a_idx  = (LEVEL == 0) ? '0 : rd_a_addr[IDX_W-1:0];
  assign b_idx  = (LEVEL == 0) ? '0 : rd_b_addr[IDX_W-1:0];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en && wr_hit) begin
      mem[wr_idx] <= wr_data;
    end
    a_q_r   <= mem[a_idx];
    b_q_r   <= mem[b_idx];
    a_hit_r <= a_hit;
    b_hit_r <= b_hit;
  end

  assign rd_a_data = a_hit_r ? a_q_r : '0;
  assign rd_b_data = b_hit_r ? b_q_r : '0;

endmodule

### hdl/hmq_pos_map.sv
// ---------------------------------------------------------------------------
// hmq_pos_map
// Map from entry id to 1-based heap position (zero means absent).
// One write port, one registered read port.
// ---------------------------------------------------------------------------
module hmq_pos_map #(
  parameter int ID_BITS = 10,
  parameter int POS_W   = 9
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ID_BITS-1:0] wr_addr,
  input  logic [POS_W-1:0]   wr_data,
  input  logic [ID_BITS-1:0] rd_addr,
  output logic [POS_W-1:0]   rd_data
);

  logic [POS_W-1:0] mem [1 << ID_BITS];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/indexed_min_heap_queue_unit.sv
// ---------------------------------------------------------------------------
// indexed_min_heap_queue_unit
// Addressable min-priority queue on a chain of heap-level cells.
// One item at a time: accept, id lookup, then a fetch and a compare state per
// heap level walked by the sift sequencer, then the result is handed to the
// output register; the next input transfer is taken only after that hand-over.
// After reset the position map is swept clear, one id a cycle, over all
// 2^ID_BITS ids (1024 by default); in_tready stays low until the sweep ends.
// ---------------------------------------------------------------------------
`include "indexed_min_heap_queue_unit_assert.svh"

module indexed_min_heap_queue_unit #(
  parameter int CAPACITY = 256,
  parameter int ID_BITS  = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // config
  input  logic                    cfg_wr_en,
  input  logic [hmq_pkg::CFG_W-1:0] cfg_wr_data, // capacity_limit
  // input stream
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // func, entry_id, new_key, payload
  input  logic [((hmq_pkg::FUNC_W + ID_BITS + hmq_pkg::KEY_W + hmq_pkg::PL_W + 7) / 8)
                * 8 - 1:0]        in_tdata,
  // result stream
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // status, out_id, out_key, out_payload, entry_count
  output logic [((hmq_pkg::STAT_W + ID_BITS + hmq_pkg::KEY_W + hmq_pkg::PL_W
                  + hmq_pkg::CNT_W + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int OUT_USED = hmq_pkg::STAT_W + ID_BITS + hmq_pkg::KEY_W + hmq_pkg::PL_W
                            + hmq_pkg::CNT_W;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;
  localparam int POS_W    = $clog2(CAPACITY + 1);
  localparam int AW       = POS_W + 1;
  localparam int LVLS     = POS_W;
  localparam int ENT_W    = ID_BITS + hmq_pkg::PL_W + hmq_pkg::KEY_W;
  localparam int KW       = hmq_pkg::KEY_W;
  localparam int PW       = hmq_pkg::PL_W;
  localparam logic [POS_W-1:0] LIM_MAX = POS_W'(CAPACITY);

  typedef enum logic [10:0] {
    S_CLR  = 11'b000_0000_0001,
    S_IDLE = 11'b000_0000_0010,
    S_MAP  = 11'b000_0000_0100,
    S_SKR  = 11'b000_0000_1000,
    S_DMR  = 11'b000_0001_0000,
    S_RMR  = 11'b000_0010_0000,
    S_UP   = 11'b000_0100_0000,
    S_UPC  = 11'b000_1000_0000,
    S_DN   = 11'b001_0000_0000,
    S_DNC  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [ID_BITS-1:0]      clr_cnt_r, clr_cnt_nxt;
  hmq_pkg::func_t          func_r, func_nxt;
  logic [ID_BITS-1:0]      id_r, id_nxt;
  logic [KW-1:0]           key_r, key_nxt;
  logic [PW-1:0]           pl_r, pl_nxt;
  logic [POS_W-1:0]        fill_r, fill_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [KW-1:0]           m_key_r, m_key_nxt;
  logic [ID_BITS-1:0]      m_id_r, m_id_nxt;
  logic [PW-1:0]           m_pl_r, m_pl_nxt;
  logic                    down_after_r, down_after_nxt;
  hmq_pkg::status_t        res_status_r, res_status_nxt;
  logic [ID_BITS-1:0]      res_id_r, res_id_nxt;
  logic [KW-1:0]           res_key_r, res_key_nxt;
  logic [PW-1:0]           res_pl_r, res_pl_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        out_data_r, out_data_nxt;
  logic [hmq_pkg::CFG_W-1:0] cap_r;

  logic [POS_W-1:0]        lim;
  logic [ID_BITS-1:0]      in_id;
  logic [POS_W-1:0]        map_rd_data;
  logic                    map_we;
  logic [ID_BITS-1:0]      map_waddr, map_raddr;
  logic [POS_W-1:0]        map_wdata;
  logic                    heap_we;
  logic [AW-1:0]           heap_waddr, rd_a_addr, rd_b_addr;
  logic [ENT_W-1:0]        heap_wdata, rd_a, rd_b;
  logic [ENT_W-1:0]        lvl_a [LVLS];
  logic [ENT_W-1:0]        lvl_b [LVLS];
  logic [KW-1:0]           a_key, b_key;
  logic [PW-1:0]           a_pl, b_pl;
  logic [ID_BITS-1:0]      a_id, b_id;
  logic                    present, pick_b;
  logic [AW-1:0]           child;
  logic [ENT_W-1:0]        ch_ent;

  // heap level cells
  for (genvar g = 0; g < LVLS; g++) begin : g_lvl
    hmq_level_cell #(.LEVEL(g), .AW(AW), .ENT_W(ENT_W)) u_cell (
      .clk       (clk),
      .wr_en     (heap_we),
      .wr_addr   (heap_waddr),
      .wr_data   (heap_wdata),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (lvl_a[g]),
      .rd_b_data (lvl_b[g])
    );
  end

  // merge the cells' read data (non-addressed cells give zero)
  always_comb begin
    rd_a = '0;
    rd_b = '0;
    for (int i = 0; i < LVLS; i++) begin
      rd_a = rd_a | lvl_a[i];
      rd_b = rd_b | lvl_b[i];
    end
  end

  assign a_key = rd_a[KW-1:0];
  assign a_pl  = rd_a[KW +: PW];
  assign a_id  = rd_a[KW+PW +: ID_BITS];
  assign b_key = rd_b[KW-1:0];
  assign b_pl  = rd_b[KW +: PW];
  assign b_id  = rd_b[KW+PW +: ID_BITS];

  // id to position map
  hmq_pos_map #(.ID_BITS(ID_BITS), .POS_W(POS_W)) u_map (
    .clk     (clk),
    .wr_en   (map_we),
    .wr_addr (map_waddr),
    .wr_data (map_wdata),
    .rd_addr (map_raddr),
    .rd_data (map_rd_data)
  );

  // effective limit, saturated at CAPACITY
  always_comb begin
    if (32'(cap_r) > CAPACITY) lim = LIM_MAX;
    else                       lim = POS_W'(cap_r);
  end

  assign in_id     = in_tdata[hmq_pkg::FUNC_W +: ID_BITS];
  assign in_tready = (state_r == S_IDLE);
  assign present   = (map_rd_data != '0) && (map_rd_data <= fill_r);
  assign child     = {pos_r, 1'b0};
  assign pick_b    = (child < AW'(fill_r)) && hmq_pkg::key_lt(b_key, a_key);
  assign ch_ent    = pick_b ? rd_b : rd_a;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    func_nxt       = func_r;
    id_nxt         = id_r;
    key_nxt        = key_r;
    pl_nxt         = pl_r;
    fill_nxt       = fill_r;
    pos_nxt        = pos_r;
    m_key_nxt      = m_key_r;
    m_id_nxt       = m_id_r;
    m_pl_nxt       = m_pl_r;
    down_after_nxt = down_after_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_key_nxt    = res_key_r;
    res_pl_nxt     = res_pl_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    map_we         = 1'b0;
    map_waddr      = m_id_r;
    map_wdata      = pos_r;
    map_raddr      = in_id;
    heap_we        = 1'b0;
    heap_waddr     = AW'(pos_r);
    heap_wdata     = {m_id_r, m_pl_r, m_key_r};
    rd_a_addr      = '0;
    rd_b_addr      = '0;

    case (state_r)
      S_CLR: begin
        map_we      = 1'b1;
        map_waddr   = clr_cnt_r;
        map_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt       = hmq_pkg::func_t'(in_tdata[hmq_pkg::FUNC_W-1:0]);
          id_nxt         = in_id;
          key_nxt        = in_tdata[hmq_pkg::FUNC_W+ID_BITS +: KW];
          pl_nxt         = in_tdata[hmq_pkg::FUNC_W+ID_BITS+KW +: PW];
          res_status_nxt = hmq_pkg::ST_OK;
          res_id_nxt     = '0;
          res_key_nxt    = '0;
          res_pl_nxt     = '0;
          down_after_nxt = 1'b0;
          state_nxt      = S_MAP;
        end
      end
      S_MAP: begin
        case (func_r)
          hmq_pkg::FN_INSERT: begin
            if (fill_r >= lim) begin
              res_status_nxt = hmq_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else if (present) begin
              res_status_nxt = hmq_pkg::ST_DUP;
              state_nxt      = S_DONE;
            end else begin
              fill_nxt  = POS_W'(fill_r + 1'b1);
              pos_nxt   = POS_W'(fill_r + 1'b1);
              m_key_nxt = key_r;
              m_id_nxt  = id_r;
              m_pl_nxt  = pl_r;
              state_nxt = S_UP;
            end
          end
          hmq_pkg::FN_SET_KEY: begin
            if (!present) begin
              res_status_nxt = hmq_pkg::ST_NOT_FOUND;
              state_nxt      = S_DONE;
            end else begin
              pos_nxt   = map_rd_data;
              rd_a_addr = AW'(map_rd_data);
              state_nxt = S_SKR;
            end
          end
          hmq_pkg::FN_DEL_MIN: begin
            if (fill_r == '0) begin
              res_status_nxt = hmq_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              rd_a_addr = AW'(1);
              rd_b_addr = AW'(fill_r);
              state_nxt = S_DMR;
            end
          end
          hmq_pkg::FN_REMOVE: begin
            if (!present) begin
              res_status_nxt = hmq_pkg::ST_NOT_FOUND;
              state_nxt      = S_DONE;
            end else begin
              pos_nxt   = map_rd_data;
              rd_a_addr = AW'(map_rd_data);
              rd_b_addr = AW'(fill_r);
              state_nxt = S_RMR;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      // set key: entry read, decide direction
      S_SKR: begin
        m_key_nxt = key_r;
        m_id_nxt  = a_id;
        m_pl_nxt  = a_pl;
        if (hmq_pkg::key_lt(a_key, key_r))      state_nxt = S_DN;
        else if (hmq_pkg::key_lt(key_r, a_key)) state_nxt = S_UP;
        else                                    state_nxt = S_DONE;
      end
      // delete minimum: root and last entry read
      S_DMR: begin
        res_id_nxt  = a_id;
        res_key_nxt = a_key;
        res_pl_nxt  = a_pl;
        map_we      = 1'b1;
        map_waddr   = a_id;
        map_wdata   = '0;
        if (fill_r > POS_W'(1)) begin
          fill_nxt  = fill_r - 1'b1;
          pos_nxt   = POS_W'(1);
          m_key_nxt = b_key;
          m_id_nxt  = b_id;
          m_pl_nxt  = b_pl;
          state_nxt = S_DN;
        end else begin
          fill_nxt  = '0;
          state_nxt = S_DONE;
        end
      end
      // remove: named entry and last entry read
      S_RMR: begin
        res_key_nxt = a_key;
        res_pl_nxt  = a_pl;
        map_we      = 1'b1;
        map_waddr   = id_r;
        map_wdata   = '0;
        fill_nxt    = fill_r - 1'b1;
        if (pos_r != fill_r) begin
          m_key_nxt = b_key;
          m_id_nxt  = b_id;
          m_pl_nxt  = b_pl;
          if (pos_r > POS_W'(1)) begin
            rd_a_addr      = AW'(pos_r >> 1);
            down_after_nxt = 1'b1;
            state_nxt      = S_UPC;
          end else begin
            state_nxt = S_DN;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      // sift up: fetch parent or settle at the root
      S_UP: begin
        if (pos_r > POS_W'(1)) begin
          rd_a_addr = AW'(pos_r >> 1);
          state_nxt = S_UPC;
        end else begin
          heap_we   = 1'b1;
          map_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      // sift up: compare with parent
      S_UPC: begin
        if (hmq_pkg::key_lt(m_key_r, a_key)) begin
          heap_we        = 1'b1;
          heap_wdata     = rd_a;
          map_we         = 1'b1;
          map_waddr      = a_id;
          pos_nxt        = pos_r >> 1;
          down_after_nxt = 1'b0;
          state_nxt      = S_UP;
        end else if (down_after_r) begin
          down_after_nxt = 1'b0;
          state_nxt      = S_DN;
        end else begin
          heap_we   = 1'b1;
          map_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      // sift down: fetch both children or settle
      S_DN: begin
        if (child <= AW'(fill_r)) begin
          rd_a_addr = child;
          rd_b_addr = child + 1'b1;
          state_nxt = S_DNC;
        end else begin
          heap_we   = 1'b1;
          map_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      // sift down: compare with the smaller child
      S_DNC: begin
        if (hmq_pkg::key_lt(ch_ent[KW-1:0], m_key_r)) begin
          heap_we    = 1'b1;
          heap_wdata = ch_ent;
          map_we     = 1'b1;
          map_waddr  = ch_ent[KW+PW +: ID_BITS];
          pos_nxt    = POS_W'(pick_b ? child + 1'b1 : child);
          state_nxt  = S_DN;
        end else begin
          heap_we   = 1'b1;
          map_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt                = '0;
          out_data_nxt[OUT_USED-1:0]  = {hmq_pkg::CNT_W'(fill_r), res_pl_r, res_key_r,
                                         res_id_r, res_status_r};
          out_valid_nxt               = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= hmq_pkg::CFG_W'(256);
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) cap_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    id_r         <= id_nxt;
    key_r        <= key_nxt;
    pl_r         <= pl_nxt;
    pos_r        <= pos_nxt;
    m_key_r      <= m_key_nxt;
    m_id_r       <= m_id_nxt;
    m_pl_r       <= m_pl_nxt;
    down_after_r <= down_after_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_key_r    <= res_key_nxt;
    res_pl_r     <= res_pl_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `HMQ_ASSERT_RST(a_rst_clear, !rst_n |=> state_r == S_CLR, "reset must start the map sweep")
  `HMQ_ASSERT(a_accept_map, in_tvalid && in_tready |=> state_r == S_MAP, "accept without lookup")
  `HMQ_ASSERT(a_fill_cap, fill_r <= LIM_MAX, "entry count above capacity")
  `HMQ_ASSERT(a_sift_pos, (state_r == S_UP || state_r == S_DN) |-> (pos_r != '0 && pos_r <= fill_r), "sift position outside heap")

endmodule
